// ----- rtl/besu_pkg.sv -----
// ----------------------------------------------------------------------------
// besu_pkg
// Types and constants shared by the beat aligned event scheduler modules.
// ----------------------------------------------------------------------------
package besu_pkg;

	localparam int BEAT_W  = 48;
	localparam int COORD_W = 32;
	localparam int TAG_W   = 8;
	localparam int TGT_W   = 47;
	localparam int DIV_W   = 50;
	localparam int REM_W   = 32;

	localparam logic signed [BEAT_W-1:0] BEAT_MAX = 48'sh7FFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		REQ_SCHED  = 2'd0,
		REQ_TICK   = 2'd1,
		REQ_REBASE = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED = 3'd0,
		ST_FULL     = 3'd1,
		ST_INVALID  = 3'd2,
		ST_FIRED    = 3'd3,
		ST_NONE     = 3'd4,
		ST_REBASED  = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0]                req_type;
		logic signed [BEAT_W-1:0]  beat_value;
		logic signed [COORD_W-1:0] sync_period;
		logic signed [COORD_W-1:0] sync_offset;
		logic signed [COORD_W-1:0] sync_origin;
		logic [TAG_W-1:0]          event_tag;
	} in_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [TAG_W-1:0] fired_tag;
		logic [TGT_W-1:0] target_beat;
		logic             last;
	} out_t;

	typedef struct packed {
		logic [TAG_W-1:0]          tag;
		logic signed [COORD_W-1:0] period;
		logic signed [COORD_W-1:0] offset;
		logic signed [COORD_W-1:0] origin;
		logic signed [BEAT_W-1:0]  target;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		WR_NEW    = 2'd0,
		WR_MOVE   = 2'd1,
		WR_REBASE = 2'd2
	} wr_src_t;

	typedef enum logic [1:0] {
		O_ITEM_ZERO = 2'd0,
		O_ITEM_GRID = 2'd1,
		O_PEND      = 2'd2,
		O_ZERO      = 2'd3
	} out_sel_t;

	typedef struct packed {
		logic     load_item;
		logic     cur_load;
		logic     grid_start;
		logic     grid_src_ram;
		logic     wr_en;
		wr_src_t  wr_src;
		logic     pend_load;
		logic     emit;
		out_sel_t out_sel;
		status_t  emit_status;
		logic     emit_last;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       per_bad;
		logic       fire;
		logic       grid_done;
	} stat_t;

endpackage

// ----- rtl/besu_ram.sv -----
// ----------------------------------------------------------------------------
// besu_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module besu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/besu_grid.sv -----
// ----------------------------------------------------------------------------
// besu_grid
// Iterative grid target unit: next grid point after the current beat,
// using a one bit per cycle remainder unit for up to three modulo steps.
// ----------------------------------------------------------------------------
module besu_grid import besu_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [BEAT_W-1:0]  cur,
	input  logic signed [COORD_W-1:0] per,
	input  logic signed [COORD_W-1:0] off,
	input  logic signed [COORD_W-1:0] org,
	output logic                      done,
	output logic signed [BEAT_W-1:0]  target
);

	localparam int DIFF_W = BEAT_W + 1;
	localparam int E_W    = COORD_W + 2;
	localparam int CNT_W  = $clog2(DIV_W);

	typedef enum logic [4:0] {
		G_IDLE = 5'b00001,
		G_CUR  = 5'b00010,
		G_ORG  = 5'b00100,
		G_SEL  = 5'b01000,
		G_D    = 5'b10000
	} gphase_t;

	gphase_t                   phase_q;
	logic                      done_q;
	logic signed [BEAT_W-1:0]  cur_q;
	logic signed [COORD_W-1:0] per_q;
	logic signed [COORD_W-1:0] off_q;
	logic signed [COORD_W-1:0] org_q;
	logic                      neg_q;
	logic [DIV_W-1:0]          dvd_q;
	logic [REM_W-1:0]          rem_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [E_W-1:0]     e_q;
	logic signed [BEAT_W-1:0]  target_q;

	logic [REM_W:0]            sh;
	logic [REM_W:0]            per_u;
	logic [REM_W:0]            sub;
	logic [REM_W-1:0]          rem_nx;
	logic                      last_step;
	logic [BEAT_W-1:0]         in_abs;
	logic signed [DIFF_W-1:0]  diff;
	logic [DIFF_W-1:0]         diff_abs;
	logic [REM_W-1:0]          r_fix;
	logic signed [E_W-1:0]     e_org;
	logic signed [E_W-1:0]     e_d;
	logic signed [E_W-1:0]     e_neg;
	logic signed [DIV_W-1:0]   nxt;
	logic signed [BEAT_W-1:0]  nxt_clamp;

	always_comb begin
		sh        = {rem_q, dvd_q[DIV_W-1]};
		per_u     = {1'b0, per_q};
		sub       = sh - per_u;
		rem_nx    = (sh >= per_u) ? sub[REM_W-1:0] : sh[REM_W-1:0];
		last_step = (cnt_q == '0);
		in_abs    = cur[BEAT_W-1] ? -cur : cur;
		diff      = DIFF_W'(cur_q) - DIFF_W'(org_q);
		diff_abs  = diff[DIFF_W-1] ? -diff : diff;
		// floor remainder from the truncated one
		r_fix     = (neg_q && rem_nx != '0) ? per_q - rem_nx : rem_nx;
		e_org     = E_W'(per_q) + E_W'(off_q) - $signed({2'b00, r_fix});
		e_d       = E_W'(per_q) - $signed({2'b00, rem_nx});
		e_neg     = -e_q;
		nxt       = DIV_W'(cur_q) + DIV_W'(e_q);
		if (nxt < 0) begin
			nxt_clamp = '0;
		end else if (nxt > DIV_W'(BEAT_MAX)) begin
			nxt_clamp = BEAT_MAX;
		end else begin
			nxt_clamp = nxt[BEAT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= G_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				G_IDLE: begin
					if (start) phase_q <= G_CUR;
				end
				G_CUR: begin
					if (last_step) begin
						if (rem_nx == '0) begin
							phase_q <= G_IDLE;
							done_q  <= 1'b1;
						end else begin
							phase_q <= G_ORG;
						end
					end
				end
				G_ORG: begin
					if (last_step) phase_q <= G_SEL;
				end
				G_SEL: begin
					if (e_q > 0) begin
						phase_q <= G_IDLE;
						done_q  <= 1'b1;
					end else begin
						phase_q <= G_D;
					end
				end
				G_D: begin
					if (last_step) phase_q <= G_SEL;
				end
				default: phase_q <= G_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			G_IDLE: begin
				if (start) begin
					cur_q <= cur;
					per_q <= per;
					off_q <= off;
					org_q <= org;
					dvd_q <= {{(DIV_W-BEAT_W){1'b0}}, in_abs};
					rem_q <= '0;
					cnt_q <= CNT_W'(DIV_W - 1);
				end
			end
			G_CUR: begin
				target_q <= cur_q;
				if (last_step) begin
					dvd_q <= {{(DIV_W-DIFF_W){1'b0}}, diff_abs};
					neg_q <= diff[DIFF_W-1];
					rem_q <= '0;
					cnt_q <= CNT_W'(DIV_W - 1);
				end else begin
					dvd_q <= dvd_q << 1;
					rem_q <= rem_nx;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			G_ORG, G_D: begin
				dvd_q <= dvd_q << 1;
				rem_q <= rem_nx;
				cnt_q <= cnt_q - 1'b1;
				if (last_step) e_q <= (phase_q == G_ORG) ? e_org : e_d;
			end
			G_SEL: begin
				target_q <= nxt_clamp;
				// offset behind the beat: step on by whole periods
				dvd_q    <= {{(DIV_W-E_W){1'b0}}, e_neg};
				rem_q    <= '0;
				cnt_q    <= CNT_W'(DIV_W - 1);
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign target = target_q;

endmodule

// ----- rtl/besu_ctrl.sv -----
// ----------------------------------------------------------------------------
// besu_ctrl
// Sequencer for schedule, tick scan and rebase walks over the queue.
// ----------------------------------------------------------------------------
module besu_ctrl import besu_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  stat_t               stat,
	output cmd_t                cmd,
	output logic [(QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1)-1:0] rd_addr,
	output logic [(QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1)-1:0] wr_addr
);

	localparam int AW = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_DISP  = 9'b000000010,
		S_SCHED = 9'b000000100,
		S_TRD   = 9'b000001000,
		S_TCHK  = 9'b000010000,
		S_TEND  = 9'b000100000,
		S_RRD   = 9'b001000000,
		S_RGO   = 9'b010000000,
		S_RWAIT = 9'b100000000
	} state_t;

	state_t         state_q, state_d;
	logic [CW-1:0]  count_q, count_d;
	logic [CW-1:0]  i_q, i_d;
	logic [CW-1:0]  keep_q, keep_d;
	logic           fired_q, fired_d;
	logic [CW-1:0]  i_inc;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		count_d = count_q;
		i_d     = i_q;
		keep_d  = keep_q;
		fired_d = fired_q;
		i_inc   = i_q + 1'b1;
		wr_addr = i_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_item = 1'b1;
					state_d       = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.req_type)
					REQ_SCHED: begin
						if (stat.per_bad) begin
							cmd.emit        = 1'b1;
							cmd.out_sel     = O_ITEM_ZERO;
							cmd.emit_status = ST_INVALID;
							cmd.emit_last   = 1'b1;
							state_d         = S_IDLE;
						end else if (count_q == CW'(QUEUE_DEPTH)) begin
							cmd.emit        = 1'b1;
							cmd.out_sel     = O_ITEM_ZERO;
							cmd.emit_status = ST_FULL;
							cmd.emit_last   = 1'b1;
							state_d         = S_IDLE;
						end else begin
							cmd.grid_start = 1'b1;
							state_d        = S_SCHED;
						end
					end
					REQ_TICK: begin
						cmd.cur_load = 1'b1;
						i_d          = '0;
						keep_d       = '0;
						fired_d      = 1'b0;
						state_d      = (count_q == '0) ? S_TEND : S_TRD;
					end
					REQ_REBASE: begin
						cmd.cur_load = 1'b1;
						i_d          = '0;
						if (count_q == '0) begin
							cmd.emit        = 1'b1;
							cmd.out_sel     = O_ZERO;
							cmd.emit_status = ST_REBASED;
							cmd.emit_last   = 1'b1;
							state_d         = S_IDLE;
						end else begin
							state_d = S_RRD;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_SCHED: begin
				wr_addr = count_q[AW-1:0];
				if (stat.grid_done) begin
					cmd.wr_en       = 1'b1;
					cmd.wr_src      = WR_NEW;
					cmd.emit        = 1'b1;
					cmd.out_sel     = O_ITEM_GRID;
					cmd.emit_status = ST_ACCEPTED;
					cmd.emit_last   = 1'b1;
					count_d         = count_q + 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_TRD: state_d = S_TCHK;
			S_TCHK: begin
				wr_addr = keep_q[AW-1:0];
				if (stat.fire) begin
					// previous fired event goes out once another one is known
					if (fired_q) begin
						cmd.emit        = 1'b1;
						cmd.out_sel     = O_PEND;
						cmd.emit_status = ST_FIRED;
					end
					cmd.pend_load = 1'b1;
					fired_d       = 1'b1;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wr_src = WR_MOVE;
					keep_d     = keep_q + 1'b1;
				end
				i_d     = i_inc;
				state_d = (i_inc == count_q) ? S_TEND : S_TRD;
			end
			S_TEND: begin
				count_d         = keep_q;
				cmd.emit        = 1'b1;
				cmd.emit_last   = 1'b1;
				cmd.out_sel     = fired_q ? O_PEND : O_ZERO;
				cmd.emit_status = fired_q ? ST_FIRED : ST_NONE;
				state_d         = S_IDLE;
			end
			S_RRD: state_d = S_RGO;
			S_RGO: begin
				cmd.grid_start   = 1'b1;
				cmd.grid_src_ram = 1'b1;
				state_d          = S_RWAIT;
			end
			S_RWAIT: begin
				if (stat.grid_done) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_src = WR_REBASE;
					i_d        = i_inc;
					if (i_inc == count_q) begin
						cmd.emit        = 1'b1;
						cmd.out_sel     = O_ZERO;
						cmd.emit_status = ST_REBASED;
						cmd.emit_last   = 1'b1;
						state_d         = S_IDLE;
					end else begin
						state_d = S_RRD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			i_q     <= '0;
			keep_q  <= '0;
			fired_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			i_q     <= i_d;
			keep_q  <= keep_d;
			fired_q <= fired_d;
		end
	end

	assign busy    = (state_q != S_IDLE);
	assign rd_addr = i_q[AW-1:0];

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_keep_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TCHK || state_q == S_TRD) |-> keep_q <= i_q)
		else $error("compaction index ahead of scan index");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_last) |=> state_q == S_IDLE)
		else $error("final result transfer without return to idle");

	a_grid_done: assert property (@(posedge clk) disable iff (!arst_n)
		stat.grid_done |-> (state_q == S_SCHED || state_q == S_RWAIT))
		else $error("grid unit finished outside a wait state");

endmodule

// ----- rtl/besu_dp.sv -----
// ----------------------------------------------------------------------------
// besu_dp
// Datapath: item and beat registers, entry memory, grid unit, result regs.
// ----------------------------------------------------------------------------
module besu_dp import besu_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  in_t   item,
	input  cmd_t  cmd,
	output stat_t stat,
	input  logic [(QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1)-1:0] rd_addr,
	input  logic [(QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1)-1:0] wr_addr,
	output logic  done,
	output out_t  result
);

	in_t                      item_q;
	logic signed [BEAT_W-1:0] cur_beat_q;
	logic [TAG_W-1:0]         pend_tag_q;
	logic signed [BEAT_W-1:0] pend_tgt_q;
	out_t                     result_q;
	logic                     done_q;

	logic [ENTRY_W-1:0]        rd_raw;
	entry_t                    rd_entry;
	entry_t                    wr_entry;
	logic                      grid_done;
	logic signed [BEAT_W-1:0]  grid_tgt;
	logic signed [COORD_W-1:0] g_per;
	logic signed [COORD_W-1:0] g_off;
	logic signed [COORD_W-1:0] g_org;
	out_t                      out_d;

	function automatic logic [TGT_W-1:0] show_target(input logic signed [BEAT_W-1:0] t);
		show_target = t[BEAT_W-1] ? '0 : t[TGT_W-1:0];
	endfunction

	assign rd_entry = entry_t'(rd_raw);

	always_comb begin
		g_per = cmd.grid_src_ram ? rd_entry.period : item_q.sync_period;
		g_off = cmd.grid_src_ram ? rd_entry.offset : item_q.sync_offset;
		g_org = cmd.grid_src_ram ? rd_entry.origin : item_q.sync_origin;

		wr_entry = rd_entry;
		case (cmd.wr_src)
			WR_NEW: begin
				wr_entry.tag    = item_q.event_tag;
				wr_entry.period = item_q.sync_period;
				wr_entry.offset = item_q.sync_offset;
				wr_entry.origin = item_q.sync_origin;
				wr_entry.target = grid_tgt;
			end
			WR_MOVE:   wr_entry = rd_entry;
			WR_REBASE: wr_entry.target = grid_tgt;
			default:   wr_entry = rd_entry;
		endcase

		out_d.status = cmd.emit_status;
		out_d.last   = cmd.emit_last;
		case (cmd.out_sel)
			O_ITEM_ZERO: begin
				out_d.fired_tag   = item_q.event_tag;
				out_d.target_beat = '0;
			end
			O_ITEM_GRID: begin
				out_d.fired_tag   = item_q.event_tag;
				out_d.target_beat = show_target(grid_tgt);
			end
			O_PEND: begin
				out_d.fired_tag   = pend_tag_q;
				out_d.target_beat = show_target(pend_tgt_q);
			end
			default: begin
				out_d.fired_tag   = '0;
				out_d.target_beat = '0;
			end
		endcase

		stat.req_type  = item_q.req_type;
		stat.per_bad   = (item_q.sync_period <= 0);
		stat.fire      = (item_q.beat_value > rd_entry.target);
		stat.grid_done = grid_done;
	end

	besu_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (wr_addr),
		.wdata (wr_entry),
		.raddr (rd_addr),
		.rdata (rd_raw)
	);

	besu_grid u_grid (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.grid_start),
		.cur    (cur_beat_q),
		.per    (g_per),
		.off    (g_off),
		.org    (g_org),
		.done   (grid_done),
		.target (grid_tgt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_beat_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.cur_load) cur_beat_q <= item_q.beat_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= item;
		if (cmd.pend_load) begin
			pend_tag_q <= rd_entry.tag;
			pend_tgt_q <= rd_entry.target;
		end
		if (cmd.emit) result_q <= out_d;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- rtl/beat_aligned_event_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// beat_aligned_event_scheduler_unit
// Ordered queue of beat-grid sync events: schedule, tick and rebase.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive item and raise start; the transfer happens on a clock edge
//   with start high and busy low. busy stays high until all results are out.
//   Output: each result sits on result for one cycle with done high. The
//   receiver cannot hold results off; every done cycle is one transfer.
//   Schedule: one result, after one remainder pass in the grid unit when the
//   current beat is a multiple of the period, two or three passes otherwise
//   (one bit per cycle); no pass for an invalid period or a full queue.
//   Tick: per queued entry, one memory read, then one compare and compaction
//   write; one result per fired event in queue order, or a single none-fired
//   result.
//   Rebase: one grid pass per queued entry, then one result.
//   Reset clears the current beat and the queue count; entry memory needs no
//   clearing pass.
// ----------------------------------------------------------------------------
module beat_aligned_event_scheduler_unit import besu_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  item,
	output logic done,
	output out_t result
);

	localparam int AW = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;

	cmd_t          cmd;
	stat_t         stat;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	besu_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.stat    (stat),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr)
	);

	besu_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cmd     (cmd),
		.stat    (stat),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.done    (done),
		.result  (result)
	);

endmodule

// ----- test/beat_aligned_event_scheduler_unit_tb.sv -----
// ----------------------------------------------------------------------------
// beat_aligned_event_scheduler_unit_tb
// Drives schedule, tick and rebase commands into the scheduler, predicts
// every result from a behavioral copy of the event queue and compares each
// result field by field as it comes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module beat_aligned_event_scheduler_unit_tb;
	import besu_pkg::*;

	localparam int  DEPTH       = 16;
	localparam int  ITEMS       = 460;
	localparam int  LIMIT       = 10000000;
	localparam longint BEAT_TOP = 64'sh7FFF_FFFF_FFFF;
	localparam longint BEAT_BOT = -64'sh8000_0000_0000;
	localparam int  ONE         = 32'h0001_0000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_t  item;
	logic done;
	out_t result;

	beat_aligned_event_scheduler_unit #(.QUEUE_DEPTH(DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	// behavioral copy of the queue
	longint cur_beat;
	int     pend_cnt;
	logic [TAG_W-1:0] pend_tag [DEPTH];
	longint pend_per [DEPTH];
	longint pend_off [DEPTH];
	longint pend_org [DEPTH];
	longint pend_tgt [DEPTH];

	out_t   exp_results[$];
	int     err_cnt;
	int     cyc_cnt;
	int     sent_cnt;
	bit     gaps_on;
	longint beat_cursor;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (cyc_cnt > LIMIT) begin
			$display("beat_aligned_event_scheduler_unit_tb failed");
			$finish;
		end
	end

	function automatic longint floor_quot(longint a, longint p);
		longint q;
		q = a / p;
		if ((a % p) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	// first grid point past cur; aligned beat returns itself unclamped
	function automatic longint next_grid(longint cur, longint p, longint off, longint org);
		longint pt;
		if (p <= 0)
			return cur;
		if (cur % p == 0)
			return cur;
		pt = (floor_quot(cur - org, p) + 1) * p + org + off;
		if (pt <= cur)
			pt = pt + ((cur - pt) / p + 1) * p;
		if (pt < 0)
			pt = 0;
		if (pt > BEAT_TOP)
			pt = BEAT_TOP;
		return pt;
	endfunction

	function automatic void push_result(status_t st, logic [TAG_W-1:0] tag, longint tgt,
			logic lst);
		out_t r;
		r.status      = st;
		r.fired_tag   = tag;
		r.target_beat = (tgt < 0) ? '0 : tgt[TGT_W-1:0];
		r.last        = lst;
		exp_results   = {exp_results, r};
	endfunction

	function automatic void predict_item(in_t it);
		longint beat, per, off, org, tgt;
		int keep, nfired;
		beat = longint'(it.beat_value);
		per  = longint'(it.sync_period);
		off  = longint'(it.sync_offset);
		org  = longint'(it.sync_origin);
		case (req_t'(it.req_type))
			REQ_SCHED: begin
				if (per <= 0)
					push_result(ST_INVALID, it.event_tag, 0, 1'b1);
				else if (pend_cnt >= DEPTH)
					push_result(ST_FULL, it.event_tag, 0, 1'b1);
				else begin
					tgt = next_grid(cur_beat, per, off, org);
					pend_tag[pend_cnt] = it.event_tag;
					pend_per[pend_cnt] = per;
					pend_off[pend_cnt] = off;
					pend_org[pend_cnt] = org;
					pend_tgt[pend_cnt] = tgt;
					pend_cnt++;
					push_result(ST_ACCEPTED, it.event_tag, tgt, 1'b1);
				end
			end
			REQ_TICK: begin
				cur_beat = beat;
				keep = 0;
				nfired = 0;
				for (int i = 0; i < pend_cnt; i++) begin
					if (beat > pend_tgt[i]) begin
						push_result(ST_FIRED, pend_tag[i], pend_tgt[i], 1'b0);
						nfired++;
					end else begin
						pend_tag[keep] = pend_tag[i];
						pend_per[keep] = pend_per[i];
						pend_off[keep] = pend_off[i];
						pend_org[keep] = pend_org[i];
						pend_tgt[keep] = pend_tgt[i];
						keep++;
					end
				end
				pend_cnt = keep;
				if (nfired == 0)
					push_result(ST_NONE, '0, 0, 1'b1);
				else
					exp_results[$].last = 1'b1;
			end
			REQ_REBASE: begin
				for (int i = 0; i < pend_cnt; i++)
					pend_tgt[i] = next_grid(beat, pend_per[i], pend_off[i], pend_org[i]);
				cur_beat = beat;
				push_result(ST_REBASED, '0, 0, 1'b1);
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		out_t e;
		if (done) begin
			if (exp_results.size() == 0) begin
				$error("unexpected result status=%0d tag=%0d", result.status,
					result.fired_tag);
				err_cnt++;
			end else begin
				e = exp_results.pop_front();
				if (result.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, result.status);
					err_cnt++;
				end
				if (result.fired_tag !== e.fired_tag) begin
					$error("fired_tag: expected %0d, got %0d", e.fired_tag,
						result.fired_tag);
					err_cnt++;
				end
				if (result.target_beat !== e.target_beat) begin
					$error("target_beat: expected %0h, got %0h", e.target_beat,
						result.target_beat);
					err_cnt++;
				end
				if (result.last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, result.last);
					err_cnt++;
				end
			end
		end
	end

	function automatic in_t make_item(req_t rq, longint beat, int per, int off, int org,
			int tag);
		in_t it;
		it.req_type    = rq;
		it.beat_value  = beat[BEAT_W-1:0];
		it.sync_period = per;
		it.sync_offset = off;
		it.sync_origin = org;
		it.event_tag   = tag[TAG_W-1:0];
		return it;
	endfunction

	// called at a falling edge, returns at a falling edge after the transfer
	task automatic send_item(in_t it);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		start = 1'b1;
		item  = it;
		do @(posedge clk); while (busy);
		predict_item(it);
		sent_cnt++;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic drain_results();
		while (exp_results.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic test_idle_tick();
		send_item(make_item(REQ_TICK, 0, 0, 0, 0, 0));
		send_item(make_item(REQ_NONE, 48'h1234, ONE, 0, 0, 9));
	endtask

	task automatic test_schedule_cases();
		send_item(make_item(REQ_SCHED, 0, 0, 0, 0, 8'hFF));
		send_item(make_item(REQ_SCHED, 0, 32'h8000_0000, 0, 0, 1));
		// aligned beat at zero
		send_item(make_item(REQ_SCHED, 0, ONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 2));
		send_item(make_item(REQ_TICK, 64'h5_8000, 0, 0, 0, 0));
		send_item(make_item(REQ_SCHED, 0, ONE, 32'h8000, 32'h3000, 3));
		// offset behind the beat
		send_item(make_item(REQ_SCHED, 0, ONE, 32'h8000_0001, 0, 4));
		send_item(make_item(REQ_SCHED, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 5));
		send_item(make_item(REQ_SCHED, 0, 3, 32'hFFFF_0000, 32'h7FFF_FFFF, 6));
	endtask

	task automatic test_rebase_edges();
		// saturation near the top of the beat range
		send_item(make_item(REQ_REBASE, BEAT_TOP - 5, 0, 0, 0, 0));
		send_item(make_item(REQ_TICK, BEAT_BOT, 0, 0, 0, 0));
		// aligned negative beat keeps negative targets
		send_item(make_item(REQ_REBASE, -64'sh30000, 0, 0, 0, 0));
		send_item(make_item(REQ_SCHED, 0, ONE, 0, 0, 7));
		send_item(make_item(REQ_TICK, -64'sh2FFFF, 0, 0, 0, 0));
		send_item(make_item(REQ_TICK, BEAT_TOP, 0, 0, 0, 0));
	endtask

	task automatic test_full_queue();
		send_item(make_item(REQ_REBASE, 64'h1_2345, 0, 0, 0, 0));
		for (int i = 0; i < DEPTH; i++)
			send_item(make_item(REQ_SCHED, 0, $urandom_range(1, 32'h4_0000),
				$urandom_range(0, 32'h2_0000), $urandom_range(0, 32'h2_0000), 16 + i));
		send_item(make_item(REQ_SCHED, 0, ONE, 0, 0, 8'hAA));
		send_item(make_item(REQ_SCHED, 0, 32'hFFFF_FFFF, 0, 0, 8'h55));
		send_item(make_item(REQ_REBASE, 64'h7_0000, 0, 0, 0, 0));
		send_item(make_item(REQ_TICK, BEAT_TOP, 0, 0, 0, 0));
	endtask

	function automatic int pick_coord(int span);
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return $urandom_range(0, span) - span / 2;
	endfunction

	task automatic test_random();
		int r, per, n;
		longint beat;
		n = 0;
		beat_cursor = cur_beat;
		while (n < ITEMS - 40) begin
			if (n == 200)
				while (exp_results.size() != 0)
					@(negedge clk);
			gaps_on = (n < ITEMS - 120);
			r = $urandom_range(0, 99);
			if (r < 55) begin
				per = ($urandom_range(0, 7) == 0) ? ($urandom & 32'h7FFF_FFFF) :
					$urandom_range(1, 32'h4_0000);
				if (per == 0)
					per = 1;
				send_item(make_item(REQ_SCHED, {$urandom, $urandom}, per,
					pick_coord(32'h8_0000), pick_coord(32'h8_0000), $urandom));
			end else if (r < 60) begin
				per = ($urandom_range(0, 1) == 0) ? 0 : ($urandom | 32'h8000_0000);
				send_item(make_item(REQ_SCHED, {$urandom, $urandom}, per,
					$urandom, $urandom, $urandom));
			end else if (r < 85) begin
				beat_cursor = beat_cursor + $urandom_range(0, 32'h6_0000) - 32'h1_0000;
				beat = ($urandom_range(0, 15) == 0) ? longint'($signed({$urandom, $urandom}
					>> 16)) : beat_cursor;
				send_item(make_item(REQ_TICK, beat, $urandom, $urandom, $urandom, $urandom));
			end else if (r < 95) begin
				if ($urandom_range(0, 5) == 0)
					beat_cursor = longint'($signed({$urandom, $urandom} >> 16));
				else if ($urandom_range(0, 3) == 0)
					beat_cursor = (beat_cursor >>> 16) << 16;
				else
					beat_cursor = beat_cursor + $urandom_range(0, 32'h4_0000) - 32'h2_0000;
				send_item(make_item(REQ_REBASE, beat_cursor, $urandom, $urandom, $urandom,
					$urandom));
			end else begin
				send_item(make_item(REQ_NONE, {$urandom, $urandom}, $urandom, $urandom,
					$urandom, $urandom));
				n--;
			end
			n++;
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		item        = '0;
		cur_beat    = 0;
		pend_cnt    = 0;
		err_cnt     = 0;
		cyc_cnt     = 0;
		sent_cnt    = 0;
		gaps_on     = 1'b1;
		beat_cursor = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_idle_tick();
		test_schedule_cases();
		test_rebase_edges();
		test_full_queue();
		test_random();
		drain_results();
		if (err_cnt == 0)
			$display("beat_aligned_event_scheduler_unit_tb passed");
		else
			$display("beat_aligned_event_scheduler_unit_tb failed");
		$finish;
	end

endmodule
